FILE: hdl/nearest_palette_color_unit_assert.svh
// assertion macros shared by the nearest palette color unit
`ifndef NEAREST_PALETTE_COLOR_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_UNIT_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npc assertion failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npc assertion failed");

`endif

FILE: hdl/npc_pkg.sv
// types and constants of the nearest palette color unit
package npc_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 8;
   localparam int END_W = 9;
   localparam int SQ_W = 16;
   localparam int DIST_W = 18;
   localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 257 * 257);

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // distance unit result toward the sequencer
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] idx;
      logic [DIST_W-1:0]  dist_val;
   } dist_res_type;

   // sequencer commands toward the memory and distance unit
   typedef struct packed {
      logic               issue;
      logic [INDEX_W-1:0] addr;
      logic               flush;
   } ctrl_type;

endpackage

FILE: hdl/npc_dist.sv
// shared distance unit: squared channel differences, then their sum
module npc_dist (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [npc_pkg::INDEX_W-1:0]      in_idx,
   input  logic [3*npc_pkg::COLOR_W-1:0]    entry,
   input  logic [npc_pkg::COLOR_W-1:0]      q_red,
   input  logic [npc_pkg::COLOR_W-1:0]      q_green,
   input  logic [npc_pkg::COLOR_W-1:0]      q_blue,
   input  logic                             flush,
   output npc_pkg::dist_res_type            res
);

   logic [npc_pkg::COLOR_W-1:0] d_r, d_g, d_b;
   logic [npc_pkg::COLOR_W-1:0] e_r, e_g, e_b;
   logic [npc_pkg::SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npc_pkg::INDEX_W-1:0] idx_ff;
   logic                        valid_ff;

   assign e_r = entry[3*npc_pkg::COLOR_W-1:2*npc_pkg::COLOR_W];
   assign e_g = entry[2*npc_pkg::COLOR_W-1:npc_pkg::COLOR_W];
   assign e_b = entry[npc_pkg::COLOR_W-1:0];

   // absolute channel differences
   assign d_r = (q_red >= e_r) ? (q_red - e_r) : (e_r - q_red);
   assign d_g = (q_green >= e_g) ? (q_green - e_g) : (e_g - q_green);
   assign d_b = (q_blue >= e_b) ? (q_blue - e_b) : (e_b - q_blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid && !flush;
      end
   end

   always_ff @(posedge clock) begin
      sq_r_ff <= npc_pkg::SQ_W'(d_r) * npc_pkg::SQ_W'(d_r);
      sq_g_ff <= npc_pkg::SQ_W'(d_g) * npc_pkg::SQ_W'(d_g);
      sq_b_ff <= npc_pkg::SQ_W'(d_b) * npc_pkg::SQ_W'(d_b);
      idx_ff  <= in_idx;
   end

   assign res.valid    = valid_ff;
   assign res.idx      = idx_ff;
   assign res.dist_val = npc_pkg::DIST_W'(sq_r_ff) + npc_pkg::DIST_W'(sq_g_ff)
                       + npc_pkg::DIST_W'(sq_b_ff);

endmodule

FILE: hdl/npc_ctrl.sv
// scan sequencer: address counter, best-match tracker and result strobe
`include "nearest_palette_color_unit_assert.svh"

module npc_ctrl #(
   parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start_query,
   input  logic [npc_pkg::INDEX_W-1:0]      q_first,
   input  logic [npc_pkg::END_W-1:0]        q_end,
   input  logic                             s1_valid,
   input  npc_pkg::dist_res_type            res,
   output npc_pkg::ctrl_type                ctl,
   output logic                             busy,
   output logic                             rsp_valid,
   output logic [npc_pkg::INDEX_W-1:0]      best_index
);

   localparam logic [npc_pkg::END_W-1:0] LIMIT =
      npc_pkg::END_W'((PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256);

   npc_pkg::state_type          state_ff, state_in;
   logic [npc_pkg::INDEX_W-1:0] addr_ff, last_ff, best_ff;
   logic [npc_pkg::DIST_W-1:0]  best_dist_ff;
   logic [npc_pkg::END_W-1:0]   end_sat;
   logic                        empty, scanning, better, stop;

   // end clipped to the existing slots
   assign end_sat  = (q_end > LIMIT) ? LIMIT : q_end;
   assign empty    = {1'b0, q_first} >= end_sat;
   assign scanning = (state_ff == npc_pkg::ST_SCAN) || (state_ff == npc_pkg::ST_DRAIN);
   assign better   = scanning && res.valid && (res.dist_val < best_dist_ff);
   // exact match ends the scan
   assign stop     = better && (res.dist_val == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npc_pkg::ST_IDLE: begin
            if (start_query) begin
               state_in = empty ? npc_pkg::ST_DONE : npc_pkg::ST_SCAN;
            end
         end
         npc_pkg::ST_SCAN: begin
            if (stop) begin
               state_in = npc_pkg::ST_DONE;
            end else if (addr_ff == last_ff) begin
               state_in = npc_pkg::ST_DRAIN;
            end
         end
         npc_pkg::ST_DRAIN: begin
            if (stop || (!s1_valid && !res.valid)) begin
               state_in = npc_pkg::ST_DONE;
            end
         end
         npc_pkg::ST_DONE: begin
            state_in = npc_pkg::ST_IDLE;
         end
         default: begin
            state_in = npc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = (state_ff != npc_pkg::ST_IDLE);
      rsp_valid = (state_ff == npc_pkg::ST_DONE);
      ctl.issue = (state_ff == npc_pkg::ST_SCAN) && !stop;
      ctl.addr  = addr_ff;
      ctl.flush = stop;
   end

   assign best_index = best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_query) begin
         addr_ff      <= q_first;
         last_ff      <= npc_pkg::INDEX_W'(end_sat - npc_pkg::END_W'(1));
         best_ff      <= q_first;
         best_dist_ff <= npc_pkg::DIST_START;
      end else begin
         if (ctl.issue) begin
            addr_ff <= addr_ff + npc_pkg::INDEX_W'(1);
         end
         if (better) begin
            best_ff      <= res.idx;
            best_dist_ff <= res.dist_val;
         end
      end
   end

   `NPC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy)
   `NPC_ASSERT_IMPLIES(a_issue_in_range, clock, reset, ctl.issue, addr_ff <= last_ff)
   `NPC_ASSERT_NEXT(a_exact_match_ends, clock, reset, stop, rsp_valid)
   `NPC_ASSERT_IMPLIES(a_no_start_busy, clock, reset, start_query, !busy)

endmodule

FILE: hdl/nearest_palette_color_unit.sv
// top level of the nearest palette color unit: palette memory and port glue
// A write beat (req_func = 0) stores one RGB entry in the palette in the cycle
// it is accepted and gives no response; busy stays low. A query beat
// (req_func = 1) scans slots req_range_first up to req_range_end - 1 (end
// clipped to the palette size and 256), reading one palette entry per cycle
// through the single memory read port into a shared squared-distance unit.
// The response strobe rsp_valid is high once the last slot has passed the
// read register and the distance unit, earlier on an exact match, which ends
// the scan; an empty range answers with req_range_first in the cycle after
// accept. busy is high from the cycle after accept up to and including the
// response cycle. The response is on rsp_best_index for exactly that one cycle
// and the receiver cannot stall it; ties go to the lowest slot. Reading a slot
// never written gives an unspecified answer.
module nearest_palette_color_unit #(
   parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [npc_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [npc_pkg::COLOR_W-1:0]      req_red,
   input  logic [npc_pkg::COLOR_W-1:0]      req_green,
   input  logic [npc_pkg::COLOR_W-1:0]      req_blue,
   input  logic [npc_pkg::INDEX_W-1:0]      req_range_first,
   input  logic [npc_pkg::END_W-1:0]        req_range_end,
   output logic                             rsp_valid,
   output logic [npc_pkg::INDEX_W-1:0]      rsp_best_index
);

   localparam int AddrW = $clog2(PALETTE_DEPTH);
   localparam int IdxW  = (AddrW > npc_pkg::INDEX_W) ? AddrW : npc_pkg::INDEX_W;
   localparam int EntW  = 3 * npc_pkg::COLOR_W;

   // palette storage, red in the top byte
   logic [EntW-1:0]             mem [PALETTE_DEPTH];
   logic [EntW-1:0]             rd_data_ff;
   logic                        s1_valid_ff;
   logic [npc_pkg::INDEX_W-1:0] s1_idx_ff;

   // query color held for the whole scan
   logic [npc_pkg::COLOR_W-1:0] q_red_ff, q_green_ff, q_blue_ff;

   logic                        accept, wr_en, start_query;
   logic [IdxW:0]               wr_idx_ext;
   logic [IdxW-1:0]             wr_idx_wide, rd_idx_wide;
   logic [AddrW-1:0]            wr_addr, rd_addr;

   npc_pkg::ctrl_type           ctl;
   npc_pkg::dist_res_type       res;

   assign accept      = start && !busy;
   assign start_query = accept && (req_func == npc_pkg::FUNC_QUERY);

   // writes beyond the palette are dropped
   assign wr_idx_ext  = (IdxW + 1)'(req_entry_index);
   assign wr_en       = accept && (req_func == npc_pkg::FUNC_WRITE)
                      && (wr_idx_ext < (IdxW + 1)'(PALETTE_DEPTH));
   assign wr_idx_wide = IdxW'(req_entry_index);
   assign wr_addr     = wr_idx_wide[AddrW-1:0];
   assign rd_idx_wide = IdxW'(ctl.addr);
   assign rd_addr     = rd_idx_wide[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_red, req_green, req_blue};
      end
      if (ctl.issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // read stage tag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= ctl.addr;
      if (start_query) begin
         q_red_ff   <= req_red;
         q_green_ff <= req_green;
         q_blue_ff  <= req_blue;
      end
   end

   npc_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_idx   (s1_idx_ff),
      .entry    (rd_data_ff),
      .q_red    (q_red_ff),
      .q_green  (q_green_ff),
      .q_blue   (q_blue_ff),
      .flush    (ctl.flush),
      .res      (res)
   );

   npc_ctrl #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start_query (start_query),
      .q_first     (req_range_first),
      .q_end       (req_range_end),
      .s1_valid    (s1_valid_ff),
      .res         (res),
      .ctl         (ctl),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .best_index  (rsp_best_index)
   );

endmodule
